FILE: rtl/uart_pkg.sv
// Shared types and constants for the 8N1 serial transceiver.
package uart_pkg;

    localparam int unsigned TICK_W    = 9;
    localparam int unsigned BIT_IDX_W = 4;
    localparam int unsigned PERIOD_W  = 8;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd103;

    typedef struct packed {
        logic tx_level;
        logic data_ready;
        logic busy;
    } uart_flags_t;

endpackage

FILE: rtl/uart_core.sv
// Tick-by-tick transmit/receive state update of the serial transceiver.
module uart_core #(
    parameter int unsigned DATA_BITS = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [uart_pkg::PERIOD_W-1:0]    cfg_data,
    input  logic                             step,
    input  logic                             rx_level,
    input  logic                             send_request,
    input  logic [DATA_BITS-1:0]             send_byte,
    input  logic                             clear_ready,
    output uart_pkg::uart_flags_t            flags_next,
    output logic [DATA_BITS-1:0]             rx_byte_next
);
    import uart_pkg::*;

    localparam int unsigned FRAME_BITS = DATA_BITS + 2;
    localparam int unsigned IDX_W      = $clog2(DATA_BITS);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_TX   = 2'd1;
    localparam logic [1:0] PH_RX   = 2'd2;

    localparam logic [BIT_IDX_W-1:0] FRAME_CNT = BIT_IDX_W'(FRAME_BITS);
    localparam logic [BIT_IDX_W-1:0] DATA_CNT  = BIT_IDX_W'(DATA_BITS);

    logic [PERIOD_W-1:0]   bit_period_reg;
    logic [1:0]            phase_reg, phase_next;
    logic [TICK_W-1:0]     tick_count_reg, tick_count_next;
    logic [BIT_IDX_W-1:0]  bit_index_reg, bit_index_next;
    logic [FRAME_BITS-1:0] tx_shift_reg, tx_shift_next;
    logic [DATA_BITS-1:0]  rx_shift_reg, rx_shift_next;
    logic [DATA_BITS-1:0]  rx_data_reg, rx_data_next;
    logic                  ready_flag_reg, ready_flag_next;
    logic                  line_prev_reg;

    logic [TICK_W-1:0]     period_eff;
    logic [TICK_W-1:0]     rx_target;
    logic [TICK_W-1:0]     tick_inc;
    logic [BIT_IDX_W-1:0]  bit_inc;

    always_comb
    begin
        period_eff = (bit_period_reg == '0) ? TICK_W'(1) : TICK_W'(bit_period_reg);
        rx_target  = (bit_index_reg == '0) ? (period_eff + (period_eff >> 1)) : period_eff;
        tick_inc   = tick_count_reg + TICK_W'(1);
        bit_inc    = bit_index_reg + BIT_IDX_W'(1);

        phase_next      = phase_reg;
        tick_count_next = tick_count_reg;
        bit_index_next  = bit_index_reg;
        tx_shift_next   = tx_shift_reg;
        rx_shift_next   = rx_shift_reg;
        rx_data_next    = rx_data_reg;
        ready_flag_next = clear_ready ? 1'b0 : ready_flag_reg;

        case (phase_reg)
            PH_TX:
            begin
                tick_count_next = tick_inc;
                if (tick_inc >= period_eff)
                begin
                    tick_count_next = '0;
                    tx_shift_next   = {1'b1, tx_shift_reg[FRAME_BITS-1:1]};
                    bit_index_next  = bit_inc;
                    if (bit_inc >= FRAME_CNT)
                    begin
                        phase_next     = PH_IDLE;
                        bit_index_next = '0;
                        tx_shift_next  = '1;
                    end
                end
            end
            PH_RX:
            begin
                tick_count_next = tick_inc;
                if (tick_inc >= rx_target)
                begin
                    tick_count_next = '0;
                    if (bit_index_reg < DATA_CNT)
                        rx_shift_next[bit_index_reg[IDX_W-1:0]] = rx_level;
                    bit_index_next = bit_inc;
                    if (bit_inc >= DATA_CNT)
                    begin
                        rx_data_next    = rx_shift_next;
                        ready_flag_next = 1'b1;
                        phase_next      = PH_IDLE;
                        bit_index_next  = '0;
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                if (send_request)
                begin
                    tx_shift_next   = {1'b1, send_byte, 1'b0};
                    tick_count_next = '0;
                    bit_index_next  = '0;
                    phase_next      = PH_TX;
                end
                else if (line_prev_reg && !rx_level)
                begin
                    tick_count_next = '0;
                    bit_index_next  = '0;
                    rx_shift_next   = '0;
                    phase_next      = PH_RX;
                end
            end
        endcase

        flags_next.tx_level   = tx_shift_next[0];
        flags_next.data_ready = ready_flag_next;
        flags_next.busy       = (phase_next != PH_IDLE);
        rx_byte_next          = rx_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_period_reg <= PERIOD_RESET;
        end
        else if (cfg_we)
        begin
            bit_period_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            tick_count_reg <= '0;
            bit_index_reg  <= '0;
            tx_shift_reg   <= '1;
            rx_shift_reg   <= '0;
            rx_data_reg    <= '0;
            ready_flag_reg <= 1'b0;
            line_prev_reg  <= 1'b1;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            tick_count_reg <= tick_count_next;
            bit_index_reg  <= bit_index_next;
            tx_shift_reg   <= tx_shift_next;
            rx_shift_reg   <= rx_shift_next;
            rx_data_reg    <= rx_data_next;
            ready_flag_reg <= ready_flag_next;
            line_prev_reg  <= rx_level;
        end
    end

endmodule

FILE: rtl/uart_out_reg.sv
// Result register with valid/ready handshake toward the consumer.
module uart_out_reg #(
    parameter int unsigned DATA_BITS = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  uart_pkg::uart_flags_t  flags_in,
    input  logic [DATA_BITS-1:0]   byte_in,
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic                   can_load,
    output uart_pkg::uart_flags_t  flags_out,
    output logic [DATA_BITS-1:0]   byte_out
);
    import uart_pkg::*;

    logic                  valid_reg;
    uart_flags_t           flags_reg;
    logic [DATA_BITS-1:0]  byte_reg;

    assign can_load  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign flags_out = flags_reg;
    assign byte_out  = byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            flags_reg <= flags_in;
            byte_reg  <= byte_in;
        end
    end

endmodule

FILE: rtl/uart_8n1_transceiver.sv
// Top level of the half-duplex 8N1 serial transceiver.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  cfg      | cfg_valid/cfg_ready  | cfg_data (bit_period)
//  in       | in_valid/in_ready    | rx_level, send_request, send_byte, clear_ready
//  out      | out_valid/out_ready  | tx_level, rx_byte, data_ready, busy_res
//
//  One tick per cycle while in_ready is high: each input transfer updates the
//  frame state and loads the result register in the same cycle, valid next cycle.
//  in_ready stays high while the result register is empty or being drained,
//  so input stalls only when out_ready holds a result back.
//  cfg_ready is always high. Reset clears all frame state, bit_period = 103.
module uart_8n1_transceiver #(
    parameter int unsigned DATA_BITS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [uart_pkg::PERIOD_W-1:0] cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          rx_level,
    input  logic                          send_request,
    input  logic [DATA_BITS-1:0]          send_byte,
    input  logic                          clear_ready,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          tx_level,
    output logic [DATA_BITS-1:0]          rx_byte,
    output logic                          data_ready,
    output logic                          busy_res
);
    import uart_pkg::*;

    logic                 step;
    uart_flags_t          flags_next;
    uart_flags_t          flags_out;
    logic [DATA_BITS-1:0] rx_byte_next;

    assign cfg_ready = 1'b1;
    assign step      = in_valid && in_ready;

    uart_core #(
        .DATA_BITS (DATA_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_valid),
        .cfg_data     (cfg_data),
        .step         (step),
        .rx_level     (rx_level),
        .send_request (send_request),
        .send_byte    (send_byte),
        .clear_ready  (clear_ready),
        .flags_next   (flags_next),
        .rx_byte_next (rx_byte_next)
    );

    uart_out_reg #(
        .DATA_BITS (DATA_BITS)
    ) u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step),
        .flags_in  (flags_next),
        .byte_in   (rx_byte_next),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .can_load  (in_ready),
        .flags_out (flags_out),
        .byte_out  (rx_byte)
    );

    assign tx_level   = flags_out.tx_level;
    assign data_ready = flags_out.data_ready;
    assign busy_res   = flags_out.busy;

endmodule

FILE: test/uart_checker.sv
// Result checker for the 8N1 transceiver: predicts every tick and compares transfers.
`timescale 1ns / 100ps

module uart_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [uart_pkg::PERIOD_W-1:0] cfg_data,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic                          rx_level,
    input  logic                          send_request,
    input  logic [7:0]                    send_byte,
    input  logic                          clear_ready,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic                          tx_level,
    input  logic [7:0]                    rx_byte,
    input  logic                          data_ready,
    input  logic                          busy_res,
    output int                            fail_count,
    output int                            pending
);
    import uart_pkg::*;

    localparam int FRAME_LEN = 10;
    localparam int DATA_LEN  = 8;

    typedef enum logic [1:0] {
        LINK_IDLE = 2'd0,
        LINK_SEND = 2'd1,
        LINK_RECV = 2'd2
    } link_phase_t;

    typedef struct packed {
        logic       tx_level;
        logic [7:0] rx_byte;
        logic       data_ready;
        logic       busy;
    } line_result_t;

    line_result_t expected_lines[$];

    logic [PERIOD_W-1:0]  cell_ticks  = PERIOD_RESET;
    link_phase_t          link_phase  = LINK_IDLE;
    logic [TICK_W-1:0]    tick_cnt    = '0;
    logic [BIT_IDX_W-1:0] bit_cnt     = '0;
    logic [9:0]           tx_frame    = '1;
    logic [7:0]           rx_gather   = '0;
    logic [7:0]           rx_latched  = '0;
    logic                 ready_bit   = 1'b0;
    logic                 line_before = 1'b1;

    initial fail_count = 0;
    initial pending = 0;

    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    function automatic line_result_t predict_line_tick(input logic rx, input logic req,
                                                       input logic [7:0] data, input logic clr);
        logic [TICK_W-1:0] cell_len;
        logic [TICK_W-1:0] target;
        line_result_t      res;
        cell_len = (cell_ticks == '0) ? TICK_W'(1) : TICK_W'(cell_ticks);
        if (clr)
            ready_bit = 1'b0;
        case (link_phase)
            LINK_SEND:
            begin
                tick_cnt = tick_cnt + 1'b1;
                if (tick_cnt >= cell_len)
                begin
                    tick_cnt = '0;
                    tx_frame = {1'b1, tx_frame[9:1]};
                    bit_cnt  = bit_cnt + 1'b1;
                    if (bit_cnt >= FRAME_LEN)
                    begin
                        link_phase = LINK_IDLE;
                        bit_cnt    = '0;
                        tx_frame   = '1;
                    end
                end
            end
            LINK_RECV:
            begin
                target   = (bit_cnt == '0) ? cell_len + (cell_len >> 1) : cell_len;
                tick_cnt = tick_cnt + 1'b1;
                if (tick_cnt >= target)
                begin
                    tick_cnt = '0;
                    if (bit_cnt < DATA_LEN)
                        rx_gather[bit_cnt[2:0]] = rx_gather[bit_cnt[2:0]] | rx;
                    bit_cnt = bit_cnt + 1'b1;
                    if (bit_cnt >= DATA_LEN)
                    begin
                        rx_latched = rx_gather;
                        ready_bit  = 1'b1;
                        link_phase = LINK_IDLE;
                        bit_cnt    = '0;
                    end
                end
            end
            default:
            begin
                link_phase = LINK_IDLE;
                if (req)
                begin
                    tx_frame   = {1'b1, data, 1'b0};
                    tick_cnt   = '0;
                    bit_cnt    = '0;
                    link_phase = LINK_SEND;
                end
                else if (line_before && !rx)
                begin
                    tick_cnt   = '0;
                    bit_cnt    = '0;
                    rx_gather  = '0;
                    link_phase = LINK_RECV;
                end
            end
        endcase
        line_before    = rx;
        res.tx_level   = tx_frame[0];
        res.rx_byte    = rx_latched;
        res.data_ready = ready_bit;
        res.busy       = (link_phase != LINK_IDLE);
        return res;
    endfunction

    always @(posedge clk)
    begin
        line_result_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                cell_ticks = cfg_data;
            if (out_valid && out_ready)
            begin
                if (expected_lines.size() == 0)
                    report_mismatch("result transfer with nothing expected");
                else
                begin
                    want = expected_lines.pop_front();
                    if (tx_level !== want.tx_level)
                        report_mismatch($sformatf("tx_level got %b want %b",
                                                  tx_level, want.tx_level));
                    if (rx_byte !== want.rx_byte)
                        report_mismatch($sformatf("rx_byte got %h want %h",
                                                  rx_byte, want.rx_byte));
                    if (data_ready !== want.data_ready)
                        report_mismatch($sformatf("data_ready got %b want %b",
                                                  data_ready, want.data_ready));
                    if (busy_res !== want.busy)
                        report_mismatch($sformatf("busy_res got %b want %b",
                                                  busy_res, want.busy));
                end
            end
            if (in_valid && in_ready)
                expected_lines.push_back(predict_line_tick(rx_level, send_request,
                                                           send_byte, clear_ready));
            pending <= expected_lines.size();
        end
    end

endmodule

FILE: test/testbench.sv
// Stimulus, handshake pacing and verdict for the 8N1 transceiver.
`timescale 1ns / 100ps

module testbench;

    import uart_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                cfg_valid    = 1'b0;
    logic                cfg_ready;
    logic [PERIOD_W-1:0] cfg_data     = PERIOD_RESET;
    logic                in_valid     = 1'b0;
    logic                in_ready;
    logic                rx_level     = 1'b1;
    logic                send_request = 1'b0;
    logic [7:0]          send_byte    = '0;
    logic                clear_ready  = 1'b0;
    logic                out_valid;
    logic                out_ready    = 1'b0;
    logic                tx_level;
    logic [7:0]          rx_byte;
    logic                data_ready;
    logic                busy_res;

    int   fail_count;
    int   pending;
    int   idle_pct   = 0;
    int   stall_pct  = 0;
    int   hold_asked = 0;
    int   hold_seen  = 0;
    int   hold_left  = 0;
    int   quiet      = 0;
    int   line_ticks = 0;
    int   baud       = PERIOD_RESET;
    logic link_busy  = 1'b0;

    always #5 clk = ~clk;

    uart_8n1_transceiver dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_level     (rx_level),
        .send_request (send_request),
        .send_byte    (send_byte),
        .clear_ready  (clear_ready),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .tx_level     (tx_level),
        .rx_byte      (rx_byte),
        .data_ready   (data_ready),
        .busy_res     (busy_res)
    );

    uart_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_level     (rx_level),
        .send_request (send_request),
        .send_byte    (send_byte),
        .clear_ready  (clear_ready),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .tx_level     (tx_level),
        .rx_byte      (rx_byte),
        .data_ready   (data_ready),
        .busy_res     (busy_res),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // receiver pacing; a requested hold-off is counted here
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (hold_seen != hold_asked)
        begin
            hold_seen <= hold_asked;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
        if (out_valid && out_ready)
            link_busy <= busy_res;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            quiet <= 0;
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    function automatic logic coin(input int pct);
        return $urandom_range(99) < pct;
    endfunction

    task automatic put_tick(input logic rx, input logic req, input logic [7:0] data,
                            input logic clr);
        if (coin(idle_pct))
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while (coin(idle_pct));
        end
        in_valid     <= 1'b1;
        rx_level     <= rx;
        send_request <= req;
        send_byte    <= data;
        clear_ready  <= clr;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        line_ticks++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // run idle ticks until the last frame has finished
    task automatic settle_link();
        drain_results();
        while (link_busy)
        begin
            repeat (32)
                put_tick(1'b1, 1'b0, 8'($urandom_range(255)), 1'b0);
            drain_results();
        end
    endtask

    task automatic write_period(input logic [PERIOD_W-1:0] p);
        settle_link();
        repeat (4)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= p;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        baud = p;
    endtask

    task automatic idle_line(input int n, input int clr_pct);
        repeat (n)
            put_tick(1'b1, 1'b0, 8'($urandom_range(255)), coin(clr_pct));
    endtask

    task automatic rx_frame(input logic [7:0] data, input int clr_pct, input int req_pct);
        logic [9:0] frame;
        int         bit_len;
        frame = {1'b1, data, 1'b0};
        for (int i = 0; i < 10; i++)
        begin
            bit_len = baud;
            if (baud >= 4 && $urandom_range(7) == 0)
                bit_len = baud + int'($urandom_range(2)) - 1;
            repeat (bit_len)
                put_tick(frame[i], coin(req_pct), 8'($urandom_range(255)), coin(clr_pct));
        end
    endtask

    task automatic tx_frame(input logic [7:0] data, input logic first_rx, input int clr_pct);
        int n;
        n = 10 * baud + int'($urandom_range(3));
        put_tick(first_rx, 1'b1, data, coin(clr_pct));
        repeat (n)
            put_tick(!coin(15), coin(4), 8'($urandom_range(255)), coin(clr_pct));
    endtask

    task automatic run_phase(input logic [PERIOD_W-1:0] p, input int idle, input int stall,
                             input int budget, input logic press);
        int first;
        int pick;
        write_period(p);
        idle_pct  = idle;
        stall_pct = stall;
        first     = line_ticks;
        if (press)
            hold_asked++;
        while (line_ticks - first < budget)
        begin
            pick = $urandom_range(99);
            idle_line($urandom_range(1, 3), 10);
            if (pick < 45)
                rx_frame(8'($urandom_range(255)), 8, 4);
            else if (pick < 70)
                tx_frame(8'($urandom_range(255)), 1'b1, 8);
            else if (pick < 78)
                tx_frame(8'($urandom_range(255)), 1'b0, 8);
            else if (pick < 89)
                repeat (3 * baud)
                    put_tick(coin(50), coin(6), 8'($urandom_range(255)), coin(10));
            else
            begin
                // start bit cut short, line returns high
                repeat ($urandom_range(1, baud))
                    put_tick(1'b0, 1'b0, 8'($urandom_range(255)), coin(10));
                idle_line(9 * baud, 10);
            end
        end
    endtask

    initial
    begin
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_period(8'd2);

        // clear on empty flag, send beside a start edge, busy requests
        put_tick(1'b1, 1'b0, 8'hFF, 1'b1);
        put_tick(1'b0, 1'b1, 8'h00, 1'b0);
        put_tick(1'b1, 1'b1, 8'hFF, 1'b0);
        for (int i = 0; i < 6; i++)
            put_tick(i[0], 1'b0, 8'hFF, 1'b0);

        write_period(8'd2);
        idle_line(2, 0);
        rx_frame(8'h00, 100, 0);
        rx_frame(8'hFF, 0, 0);
        idle_line(2, 0);
        tx_frame(8'hFF, 1'b1, 0);
        idle_line(2, 0);

        run_phase(8'd2, 0, 0, 60, 1'b0);
        run_phase(8'd3, 52, 0, 60, 1'b0);
        run_phase(8'd5, 0, 52, 60, 1'b0);
        run_phase(8'd4, 12, 12, 60, 1'b0);
        run_phase(8'd7, 0, 0, 60, 1'b1);

        write_period(8'd13);
        idle_pct  = 0;
        stall_pct = 0;
        idle_line(2, 0);
        rx_frame(8'($urandom_range(255)), 6, 4);
        idle_line(2, 0);
        tx_frame(8'($urandom_range(255)), 1'b1, 6);

        run_phase(8'd9, 52, 0, 60, 1'b0);
        run_phase(8'd6, 0, 52, 60, 1'b1);
        run_phase(8'd2, 12, 12, 60, 1'b0);

        drain_results();
        repeat (8)
            @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: files.f
rtl/uart_pkg.sv
rtl/uart_core.sv
rtl/uart_out_reg.sv
rtl/uart_8n1_transceiver.sv
test/uart_checker.sv
test/testbench.sv
